FILE: rtl/mse_pkg.sv
// shared types and constants for the matrix square engine
package mse_pkg;

    localparam int MAX_N_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;
    localparam int SIZE_W    = 4;
    localparam int OUT_W     = 40;

    // operand travelling along the cell row
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  k;
        logic [DATA_W-1:0] a;
    } chain_t;

    // element load broadcast to the cells
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] data;
    } ld_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FEED,
        ST_WAIT,
        ST_DRAIN
    } state_t;

endpackage

FILE: rtl/matrix_square_engine_unit.sv
// top level of the matrix square engine: load control, feed sequencer, cell row, output register
//
// usage
//  - s_tvalid/s_tready/s_tdata carry one element of a per request, row-major order
//  - m_tvalid/m_tready/m_tdata/m_tlast carry one element of c = a * a per request,
//    row-major, m_tlast high on the final element of the matrix
//  - cfg_we/cfg_data write the matrix size n (0 acts as 1, above MAX_N acts as MAX_N);
//    a write restarts the load of a new matrix
//  - elements are taken one per cycle while loading; the last element starts the square
//  - per product row: the row of a is fed from the ram through a row of MAX_N cells,
//    one multiply-accumulate per cell per cycle; a wait state lets the row settle,
//    then n results leave one per cycle while the receiver is ready
//  - the output register is refilled in the cycle it is taken, so a stalled receiver
//    simply holds the drain; no result is lost or repeated
//  - reset sets n to MAX_N and empties the load; no input is taken while squaring
module matrix_square_engine_unit
    import mse_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // slave side: element_value
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,
    // master side: product_value [31:0], out_row [34:32], out_col [37:35], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic                m_tlast,
    // configuration: matrix_size
    input  logic                cfg_we,
    input  logic [SIZE_W-1:0]   cfg_data
);

    localparam int DEPTH    = MAX_N * MAX_N;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WAIT_CYC = MAX_N + 2;
    localparam int WAIT_W   = $clog2(WAIT_CYC + 1);

    state_t              state_reg;
    state_t              state_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [IDX_W-1:0]    nm1;

    // load counters
    logic [ADDR_W-1:0]   ld_addr_reg;
    logic [IDX_W-1:0]    ld_row_reg;
    logic [IDX_W-1:0]    ld_col_reg;
    logic                ld_fire;
    logic                ld_last;

    // compute counters
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [IDX_W-1:0]    fk_reg;
    logic [IDX_W-1:0]    row_reg;
    logic [IDX_W-1:0]    dcol_reg;
    logic [WAIT_W-1:0]   wait_reg;
    logic                feed_d_reg;
    logic [IDX_W-1:0]    k_d_reg;

    // output register
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_val_reg;
    logic [IDX_W-1:0]    out_row_reg;
    logic [IDX_W-1:0]    out_col_reg;
    logic                out_last_reg;

    // decoded controls
    logic                feed_en;
    logic                drain_en;
    logic                out_free;
    logic                out_load;
    logic                feed_done;
    logic                wait_done;
    logic                row_done;

    logic [DATA_W-1:0]   rdata;
    ld_t                 ld_bus;
    chain_t              link [MAX_N+1];
    logic [DATA_W-1:0]   acc_link [MAX_N+1];

    // effective size minus one, clamped to the supported range
    always_comb
    begin
        if (size_reg == '0)
        begin
            nm1 = '0;
        end
        else if (size_reg > SIZE_W'(MAX_N))
        begin
            nm1 = IDX_W'(MAX_N - 1);
        end
        else
        begin
            nm1 = IDX_W'(size_reg - SIZE_W'(1));
        end
    end

    assign ld_fire   = s_tvalid && s_tready;
    assign ld_last   = (ld_row_reg == nm1) && (ld_col_reg == nm1);
    assign out_free  = !out_valid_reg || m_tready;
    assign feed_done = (fk_reg == nm1);
    assign wait_done = (wait_reg == WAIT_W'(WAIT_CYC - 1));
    assign row_done  = (dcol_reg == nm1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (ld_fire && ld_last && !cfg_we)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (feed_done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (wait_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free && row_done)
                begin
                    state_next = (row_reg == nm1) ? ST_LOAD : ST_FEED;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        feed_en  = 1'b0;
        drain_en = 1'b0;
        case (state_reg)
            ST_LOAD:  s_tready = 1'b1;
            ST_FEED:  feed_en  = 1'b1;
            ST_WAIT:  drain_en = 1'b0;
            ST_DRAIN: drain_en = 1'b1;
            default:  s_tready = 1'b0;
        endcase
    end

    assign out_load = drain_en && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            size_reg      <= SIZE_W'(MAX_N);
            ld_addr_reg   <= '0;
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            rd_addr_reg   <= '0;
            fk_reg        <= '0;
            row_reg       <= '0;
            dcol_reg      <= '0;
            wait_reg      <= '0;
            feed_d_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            feed_d_reg <= feed_en;

            // load side: a size write drops a partial matrix
            if (cfg_we)
            begin
                size_reg    <= cfg_data;
                ld_addr_reg <= '0;
                ld_row_reg  <= '0;
                ld_col_reg  <= '0;
            end
            else if (ld_fire)
            begin
                if (ld_last)
                begin
                    ld_addr_reg <= '0;
                    ld_row_reg  <= '0;
                    ld_col_reg  <= '0;
                    rd_addr_reg <= '0;
                    fk_reg      <= '0;
                    row_reg     <= '0;
                    dcol_reg    <= '0;
                end
                else
                begin
                    ld_addr_reg <= ld_addr_reg + ADDR_W'(1);
                    if (ld_col_reg == nm1)
                    begin
                        ld_col_reg <= '0;
                        ld_row_reg <= ld_row_reg + IDX_W'(1);
                    end
                    else
                    begin
                        ld_col_reg <= ld_col_reg + IDX_W'(1);
                    end
                end
            end

            // feed one row of a, read addresses run on linearly across rows
            if (feed_en)
            begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                fk_reg      <= feed_done ? '0 : fk_reg + IDX_W'(1);
                wait_reg    <= '0;
            end
            else if (state_reg == ST_WAIT)
            begin
                wait_reg <= wait_reg + WAIT_W'(1);
            end

            // drain the row out of the cells
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (row_done)
                begin
                    dcol_reg <= '0;
                    row_reg  <= (row_reg == nm1) ? '0 : row_reg + IDX_W'(1);
                end
                else
                begin
                    dcol_reg <= dcol_reg + IDX_W'(1);
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_d_reg <= fk_reg;
        if (out_load)
        begin
            out_val_reg  <= acc_link[0];
            out_row_reg  <= row_reg;
            out_col_reg  <= dcol_reg;
            out_last_reg <= (row_reg == nm1) && row_done;
        end
    end

    // row-major copy of a for the feed
    mse_ram
    #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    )
    u_store
    (
        .clk   (clk),
        .we    (ld_fire),
        .waddr (ld_addr_reg),
        .wdata (s_tdata),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    assign ld_bus.we   = ld_fire;
    assign ld_bus.row  = ld_row_reg;
    assign ld_bus.col  = ld_col_reg;
    assign ld_bus.data = s_tdata;

    // head of the cell row is the ram output aligned with its k
    assign link[0].valid   = feed_d_reg;
    assign link[0].k       = k_d_reg;
    assign link[0].a       = rdata;
    assign acc_link[MAX_N] = '0;

    // cell c accumulates c[row][c]; results shift towards cell 0 when draining
    for (genvar c = 0; c < MAX_N; c++)
    begin : g_cell
        mse_cell
        #(
            .MAX_N    (MAX_N),
            .CELL_IDX (c)
        )
        u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .chain_in  (link[c]),
            .chain_out (link[c+1]),
            .ld        (ld_bus),
            .shift     (out_load),
            .acc_in    (acc_link[c+1]),
            .acc_out   (acc_link[c])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_W - DATA_W - 2 * IDX_W)'(0), out_col_reg, out_row_reg, out_val_reg};

endmodule

FILE: rtl/mse_ram.sv
// generic single write port ram with registered read
module mse_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mse_cell.sv
// one column cell: holds a column of a, multiplies and accumulates one product element
module mse_cell
    import mse_pkg::*;
#(
    parameter int MAX_N    = MAX_N_DEF,
    parameter int CELL_IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  chain_t            chain_in,
    output chain_t            chain_out,
    input  ld_t               ld,
    input  logic              shift,
    input  logic [DATA_W-1:0] acc_in,
    output logic [DATA_W-1:0] acc_out
);

    localparam int CIDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    logic [DATA_W-1:0] col_mem [MAX_N];
    logic              fv_reg;
    logic [IDX_W-1:0]  fk_reg;
    logic [DATA_W-1:0] fa_reg;
    logic              pv_reg;
    logic [IDX_W-1:0]  pk_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] b_val;

    assign b_val = col_mem[chain_in.k[CIDX_W-1:0]];

    // column store, written when the loaded element falls in this column
    always_ff @(posedge clk)
    begin
        if (ld.we && (ld.col == IDX_W'(CELL_IDX)))
        begin
            col_mem[ld.row[CIDX_W-1:0]] <= ld.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= chain_in.valid;
            pv_reg <= chain_in.valid;
        end
    end

    // low 32 bits of the product are the same for signed and unsigned
    always_ff @(posedge clk)
    begin
        fk_reg   <= chain_in.k;
        fa_reg   <= chain_in.a;
        pk_reg   <= chain_in.k;
        prod_reg <= chain_in.a * b_val;
        if (pv_reg)
        begin
            acc_reg <= (pk_reg == '0) ? prod_reg : acc_reg + prod_reg;
        end
        else if (shift)
        begin
            acc_reg <= acc_in;
        end
    end

    assign chain_out.valid = fv_reg;
    assign chain_out.k     = fk_reg;
    assign chain_out.a     = fa_reg;
    assign acc_out         = acc_reg;

endmodule
